// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd20;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic load_write;
        logic start;
        logic mem_read;
        logic step;
        logic out_load;
    } stbs_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic key_above;
        logic slot_free;
    } stbs_status_t;

endpackage

// ===== hdl/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/stbs_dpath.sv =====
// ----------------------------------------------------------------------------
// stbs_dpath
// Table storage, search bounds, key compare and the result register.
// ----------------------------------------------------------------------------
module stbs_dpath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stbs_pkg::stbs_cmd_t                 ctl,
    output stbs_pkg::stbs_status_t              sts,
    input  logic                                cfg_write,
    input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data,
    input  logic [stbs_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  item_value,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                found,
    output logic [stbs_pkg::INDEX_W-1:0]        position
);

    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    logic [COUNT_W-1:0]       cfg_reg;
    logic [CW-1:0]            lo_reg;
    logic [CW-1:0]            end_reg;
    logic [AW-1:0]            mid_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic                     match_reg;
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [INDEX_W-1:0]       pos_reg;

    logic [CW-1:0]            count_cw;
    logic [CW-1:0]            mid_cw;
    logic [AW-1:0]            mid_addr;
    logic [AW+INDEX_W-1:0]    idx_wide;
    logic [AW+INDEX_W-1:0]    mid_wide;
    logic                     load_in_range;
    logic [DATA_W-1:0]        rd_data;

    always_comb
    begin
        if (32'(cfg_reg) > 32'(TABLE_DEPTH))
        begin
            count_cw = CW'(TABLE_DEPTH);
        end
        else
        begin
            count_cw = CW'(cfg_reg);
        end
    end

    // floor midpoint of the closed interval [lo, end - 1]
    assign mid_cw   = lo_reg + ((end_reg - lo_reg - CW'(1)) >> 1);
    assign mid_addr = mid_cw[AW-1:0];

    assign idx_wide      = {{AW{1'b0}}, entry_index};
    assign mid_wide      = {{INDEX_W{1'b0}}, mid_reg};
    assign load_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ctl.load_write && load_in_range),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data (item_value),
        .rd_en   (ctl.mem_read),
        .rd_addr (mid_addr),
        .rd_data (rd_data)
    );

    assign sts.empty     = !(lo_reg < end_reg);
    assign sts.hit       = rd_data == key_reg;
    assign sts.key_above = $signed(rd_data) < key_reg;
    assign sts.slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cfg_reg <= cfg_data;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            key_reg   <= item_value;
            lo_reg    <= '0;
            end_reg   <= count_cw;
            match_reg <= 1'b0;
        end
        if (ctl.mem_read)
        begin
            mid_reg <= mid_addr;
        end
        if (ctl.step)
        begin
            if (sts.hit)
            begin
                match_reg <= 1'b1;
            end
            else if (sts.key_above)
            begin
                lo_reg <= {1'b0, mid_reg} + CW'(1);
            end
            else
            begin
                end_reg <= {1'b0, mid_reg};
            end
        end
        if (ctl.out_load)
        begin
            found_reg <= match_reg;
            pos_reg   <= match_reg ? mid_wide[INDEX_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = pos_reg;

endmodule

// ===== hdl/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for loads and searches: one table read, then one compare, per probe.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   command,
    output logic                   in_stall,
    input  stbs_pkg::stbs_status_t sts,
    output stbs_pkg::stbs_cmd_t    ctl
);

    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_SEARCH)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        ctl.load_write = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (sts.empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.mem_read = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP:
            begin
                ctl.step   = 1'b1;
                state_next = sts.hit ? ST_DONE : ST_ISSUE;
            end
            ST_DONE:
            begin
                if (sts.slot_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Loads a table of signed words and binary searches it for a key.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid/in_stall  | command, entry_index, item_value
//  out     | output    | out_valid/out_stall| found, position
//  cfg     | input     | cfg_write          | cfg_data (entries_in_use)
//
//  A load item gives no result and does not hold in_stall high.
//  A search item holds in_stall high from acceptance to a valid result and
//  makes one table read (registered RAM output) then one compare per probe,
//  until a probe hits or the search range is empty.
//  Asynchronous active-low reset; entries_in_use resets to 20, table contents
//  are undefined until loaded.
//  A stalled result waits in the output register; a finished search holds
//  in_stall high until its result can enter that register.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [stbs_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [stbs_pkg::DATA_W-1:0]  item_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [stbs_pkg::INDEX_W-1:0]        position,
    input  logic                                cfg_write,
    input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data
);

    import stbs_pkg::*;

    stbs_cmd_t    ctl;
    stbs_status_t sts;

    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .item_value  (item_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .position    (position)
    );

endmodule

// ===== hdl/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level assertions for the sorted table binary search core.
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         command,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         found,
    input logic [stbs_pkg::INDEX_W-1:0] position
);

    import stbs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
        else $error("stalled result changed");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("miss with non-zero position");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_SEARCH |=> in_stall)
        else $error("search item not held busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_LOAD |=> !in_stall)
        else $error("load item stalled the next item");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);
